// ----- hw/rtl/l2u_pkg.sv -----
// Shared types, constants and helpers for the Latin-1 to UTF-8 transcoder.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package l2u_pkg;

    // Marker matching limits
    localparam int MARK_MAX_LEN = 8;
    localparam int LEN_W        = 4;
    localparam int POS_W        = (MARK_MAX_LEN > 1) ? $clog2(MARK_MAX_LEN) : 1;

    // Queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Byte constants
    localparam logic [7:0] ESC_LOW         = 8'hC2;
    localparam logic [7:0] ESC_HIGH        = 8'hC3;
    localparam logic [7:0] SMALL_A_TILDE   = 8'hE3;
    localparam logic [7:0] SMALL_C_CEDILLA = 8'hE7;
    localparam logic [7:0] FLIP            = 8'h40;
    localparam logic [7:0] CONT_LOW        = 8'h80;
    localparam logic [7:0] LEAD_LOW        = 8'hC0;

    // Held escape codes
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_C2   = 2'd1;
    localparam logic [1:0] HELD_C3   = 2'd2;

    // Input actions
    localparam logic ACT_CONVERT = 1'b0;
    localparam logic ACT_FINISH  = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_MARKERS_EN   = 3'd0;
    localparam logic [2:0] REG_BEGIN_MARKER = 3'd1;
    localparam logic [2:0] REG_BEGIN_LENGTH = 3'd2;
    localparam logic [2:0] REG_END_MARKER   = 3'd3;
    localparam logic [2:0] REG_END_LENGTH   = 3'd4;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_t;

    // Up to four bytes of one item, first byte in bytes[0]
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } entry_t;

    typedef struct packed {
        logic             markers_enabled;
        logic [63:0]      begin_marker;
        logic [LEN_W-1:0] begin_length;
        logic [63:0]      end_marker;
        logic [LEN_W-1:0] end_length;
    } cfg_t;

    // Restart request from a write of markers_enabled
    typedef struct packed {
        logic restart;
        logic markers_enabled;
    } ctl_t;

    // Clamp a length register to 1..MARK_MAX_LEN
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] r;
        r = n;
        if (r == '0) r = LEN_W'(1);
        if (r > LEN_W'(MARK_MAX_LEN)) r = LEN_W'(MARK_MAX_LEN);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/l2u_front.sv -----
// Front end: accepts items, tracks region, held escape and marker match,
// and builds the output bytes of each item. Depends on l2u_pkg.
`default_nettype none

module l2u_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire l2u_pkg::cfg_t   cfg,
    input  wire l2u_pkg::ctl_t   ctl,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire l2u_pkg::in_t    s_data,
    input  wire logic            q_full,
    output logic                 q_wr_en,
    output l2u_pkg::entry_t      q_wr_data
);

    logic                       in_region_reg, in_region_next;
    logic [1:0]                 held_reg, held_next;
    logic [l2u_pkg::POS_W-1:0]  pos_reg, pos_next;

    logic [7:0]                 c;
    logic [7:0]                 e;
    logic [63:0]                mk;
    logic [l2u_pkg::LEN_W-1:0]  len;
    logic [l2u_pkg::POS_W-1:0]  p;
    logic [l2u_pkg::LEN_W-1:0]  np;
    logic [l2u_pkg::POS_W-1:0]  pos_match;
    logic                       done;
    logic                       has_out;
    l2u_pkg::entry_t            ent;
    logic                       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.data_byte;
    assign e       = (held_reg == l2u_pkg::HELD_C3) ? l2u_pkg::ESC_HIGH : l2u_pkg::ESC_LOW;

    // Step the marker of the current side with restart on mismatch
    always_comb begin
        mk   = in_region_reg ? cfg.end_marker : cfg.begin_marker;
        len  = l2u_pkg::eff_len(in_region_reg ? cfg.end_length : cfg.begin_length);
        p    = ({1'b0, pos_reg} >= {1'b0, len}) ? '0 : pos_reg;
        np   = l2u_pkg::LEN_W'(p) + l2u_pkg::LEN_W'(1);
        done = 1'b0;
        if (c == mk[8*p +: 8]) begin
            if (np >= len) begin
                done      = 1'b1;
                pos_match = '0;
            end else begin
                pos_match = np[l2u_pkg::POS_W-1:0];
            end
        end else begin
            pos_match = (c == mk[7:0]) ? l2u_pkg::POS_W'(1) : '0;
        end
    end

    // Classify the item and build its bytes
    always_comb begin
        ent            = '0;
        has_out        = 1'b0;
        held_next      = held_reg;
        in_region_next = in_region_reg;
        pos_next       = pos_reg;
        if (s_data.action == l2u_pkg::ACT_FINISH) begin
            if (held_reg != l2u_pkg::HELD_NONE) begin
                ent.bytes[0] = l2u_pkg::ESC_HIGH;
                ent.bytes[1] = e ^ l2u_pkg::FLIP;
                ent.last_idx = 2'd1;
                has_out      = 1'b1;
            end
            held_next      = l2u_pkg::HELD_NONE;
            pos_next       = '0;
            in_region_next = !cfg.markers_enabled;
        end else if (in_region_reg) begin
            if (held_reg == l2u_pkg::HELD_NONE) begin
                if (c == l2u_pkg::ESC_LOW) begin
                    held_next = l2u_pkg::HELD_C2;
                end else if (c == l2u_pkg::ESC_HIGH) begin
                    held_next = l2u_pkg::HELD_C3;
                end else if (c < l2u_pkg::CONT_LOW) begin
                    ent.bytes[0] = c;
                    ent.last_idx = 2'd0;
                    has_out      = 1'b1;
                end else if (c < l2u_pkg::LEAD_LOW) begin
                    ent.bytes[0] = l2u_pkg::ESC_LOW;
                    ent.bytes[1] = c;
                    ent.last_idx = 2'd1;
                    has_out      = 1'b1;
                end else begin
                    ent.bytes[0] = l2u_pkg::ESC_HIGH;
                    ent.bytes[1] = c ^ l2u_pkg::FLIP;
                    ent.last_idx = 2'd1;
                    has_out      = 1'b1;
                end
            end else begin
                held_next = l2u_pkg::HELD_NONE;
                has_out   = 1'b1;
                if (c < l2u_pkg::CONT_LOW) begin
                    ent.bytes[0] = l2u_pkg::ESC_HIGH;
                    ent.bytes[1] = e ^ l2u_pkg::FLIP;
                    ent.bytes[2] = c;
                    ent.last_idx = 2'd2;
                end else if (c < l2u_pkg::LEAD_LOW) begin
                    // Already a valid UTF-8 pair
                    ent.bytes[0] = e;
                    ent.bytes[1] = c;
                    ent.last_idx = 2'd1;
                end else if (e == l2u_pkg::ESC_HIGH && c == l2u_pkg::ESC_HIGH) begin
                    ent.bytes[0] = l2u_pkg::ESC_HIGH;
                    ent.bytes[1] = l2u_pkg::SMALL_C_CEDILLA ^ l2u_pkg::FLIP;
                    ent.bytes[2] = l2u_pkg::ESC_HIGH;
                    ent.bytes[3] = l2u_pkg::SMALL_A_TILDE ^ l2u_pkg::FLIP;
                    ent.last_idx = 2'd3;
                end else begin
                    ent.bytes[0] = l2u_pkg::ESC_HIGH;
                    ent.bytes[1] = e ^ l2u_pkg::FLIP;
                    ent.bytes[2] = l2u_pkg::ESC_HIGH;
                    ent.bytes[3] = c ^ l2u_pkg::FLIP;
                    ent.last_idx = 2'd3;
                end
            end
            if (cfg.markers_enabled) begin
                pos_next = pos_match;
                if (done) in_region_next = 1'b0;
            end
        end else begin
            // Outside a region bytes pass unchanged
            ent.bytes[0] = c;
            ent.last_idx = 2'd0;
            has_out      = 1'b1;
            if (cfg.markers_enabled) begin
                pos_next = pos_match;
                if (done) in_region_next = 1'b1;
            end
        end
    end

    assign q_wr_en   = accept && has_out;
    assign q_wr_data = ent;

    // Advance state on each transfer; restart on reset or enable write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_region_reg <= 1'b1;
            held_reg      <= l2u_pkg::HELD_NONE;
            pos_reg       <= '0;
        end else if (ctl.restart) begin
            in_region_reg <= !ctl.markers_enabled;
            held_reg      <= l2u_pkg::HELD_NONE;
            pos_reg       <= '0;
        end else if (accept) begin
            in_region_reg <= in_region_next;
            held_reg      <= held_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/l2u_queue.sv -----
// Short queue of byte groups between front and back ends.
// Depends on l2u_pkg for the entry type and depth.
`default_nettype none

module l2u_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire l2u_pkg::entry_t  wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output l2u_pkg::entry_t       rd_data,
    output logic                  empty
);

    l2u_pkg::entry_t                 slot_reg [l2u_pkg::QUEUE_DEPTH];
    logic [l2u_pkg::QUEUE_AW-1:0]    wptr_reg, rptr_reg;
    logic [l2u_pkg::QUEUE_AW:0]      count_reg;

    assign full    = (count_reg == (l2u_pkg::QUEUE_AW+1)'(l2u_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rptr_reg];

    // Store incoming groups
    always_ff @(posedge aclk) begin
        if (wr_en) slot_reg[wptr_reg] <= wr_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (wr_en) wptr_reg <= wptr_reg + l2u_pkg::QUEUE_AW'(1);
            if (rd_en) rptr_reg <= rptr_reg + l2u_pkg::QUEUE_AW'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + (l2u_pkg::QUEUE_AW+1)'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - (l2u_pkg::QUEUE_AW+1)'(1);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && full)) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && empty)) else $error("queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (l2u_pkg::QUEUE_AW+1)'(l2u_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

// ----- hw/rtl/l2u_back.sv -----
// Back end: takes byte groups from the queue and sends one byte per
// transfer, marking the final byte of each group. Depends on l2u_pkg.
`default_nettype none

module l2u_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_empty,
    input  wire l2u_pkg::entry_t  q_rd_data,
    output logic                  q_rd_en,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output l2u_pkg::out_t         m_data
);

    l2u_pkg::entry_t ent_reg;
    logic [1:0]      idx_reg;
    logic            valid_reg;
    logic            at_last;

    assign at_last = (idx_reg == ent_reg.last_idx);
    assign q_rd_en = !q_empty && (!valid_reg || (m_ready && at_last));

    assign m_valid         = valid_reg;
    assign m_data.out_byte = ent_reg.bytes[idx_reg];
    assign m_data.last     = at_last;

    // Load a new group or step through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (q_rd_en) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_ready) begin
            if (at_last) valid_reg <= 1'b0;
            else idx_reg <= idx_reg + 2'd1;
        end
    end

    // Hold group bytes
    always_ff @(posedge aclk) begin
        if (q_rd_en) ent_reg <= q_rd_data;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/latin1_to_utf8_marked_region.sv -----
// Top level of the Latin-1 to UTF-8 transcoder: APB registers, front end,
// queue and back end. Depends on l2u_pkg, l2u_front, l2u_queue, l2u_back.
//
//   Channel  Ports                      Payload
//   input    s_valid s_ready s_data     l2u_pkg::in_t  (action, data_byte)
//   output   m_valid m_ready m_data     l2u_pkg::out_t (out_byte, last)
//   config   psel penable pwrite paddr  64-bit registers at 8*index
//
// An item is accepted whenever the queue has room; each item makes 0 to 4
// bytes, which leave one per cycle while m_ready is high, from the one-byte
// output register of the back end.
// Front and back stall independently through a two-entry queue.
// Reset is synchronous, active low, and restores the register defaults.
`default_nettype none

module latin1_to_utf8_marked_region (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire l2u_pkg::in_t    s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output l2u_pkg::out_t        m_data,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [5:0]      paddr,
    input  wire logic [63:0]     pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    l2u_pkg::cfg_t   cfg_reg;
    l2u_pkg::ctl_t   ctl;
    logic            wr;
    logic [2:0]      idx;

    logic            q_full, q_empty, q_wr_en, q_rd_en;
    l2u_pkg::entry_t q_wr_data, q_rd_data;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite && pready;

    assign ctl.restart         = wr && (idx == l2u_pkg::REG_MARKERS_EN);
    assign ctl.markers_enabled = pwdata[0];

    // Write registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.markers_enabled <= 1'b0;
            cfg_reg.begin_marker    <= '0;
            cfg_reg.begin_length    <= l2u_pkg::LEN_W'(1);
            cfg_reg.end_marker      <= '0;
            cfg_reg.end_length      <= l2u_pkg::LEN_W'(1);
        end else if (wr) begin
            unique case (idx)
                l2u_pkg::REG_MARKERS_EN:   cfg_reg.markers_enabled <= pwdata[0];
                l2u_pkg::REG_BEGIN_MARKER: cfg_reg.begin_marker    <= pwdata;
                l2u_pkg::REG_BEGIN_LENGTH: cfg_reg.begin_length    <= pwdata[l2u_pkg::LEN_W-1:0];
                l2u_pkg::REG_END_MARKER:   cfg_reg.end_marker      <= pwdata;
                l2u_pkg::REG_END_LENGTH:   cfg_reg.end_length      <= pwdata[l2u_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back registers
    always_comb begin
        unique case (idx)
            l2u_pkg::REG_MARKERS_EN:   prdata = {63'd0, cfg_reg.markers_enabled};
            l2u_pkg::REG_BEGIN_MARKER: prdata = cfg_reg.begin_marker;
            l2u_pkg::REG_BEGIN_LENGTH: prdata = {{(64-l2u_pkg::LEN_W){1'b0}}, cfg_reg.begin_length};
            l2u_pkg::REG_END_MARKER:   prdata = cfg_reg.end_marker;
            l2u_pkg::REG_END_LENGTH:   prdata = {{(64-l2u_pkg::LEN_W){1'b0}}, cfg_reg.end_length};
            default:                   prdata = '0;
        endcase
    end

    l2u_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .ctl       (ctl),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    l2u_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    l2u_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_rd_data (q_rd_data),
        .q_rd_en   (q_rd_en),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
